// File: rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// shared types and constants of the signed integer to decimal text core
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_W = 32;
	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 4;
	localparam int BIT_CNT_W = $clog2(VALUE_W);

	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
	localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
	} num_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
	} char_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} sitda_state_t;

endpackage

// File: rtl/sitda_stream_if.sv
// ----------------------------------------------------------------------------
// sitda_stream_if
// valid/ready channel carrying one item of type T
// ----------------------------------------------------------------------------
interface sitda_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/signed_int_to_decimal_ascii_core.sv
// the first character is offered after the conversion and the leading-zero skip
// a new item is taken only in idle, after the last character of the previous one
// the conversion is a bit-serial double-dabble loop, one input bit per cycle
// the leading-zero skip shifts one digit per cycle, then one character per ready cycle
// reset: arst_n low clears the state machine to idle, no item pending
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// formats a signed 32-bit number as decimal ascii text, most significant
// digit first, with a leading minus for negative values and a last-char flag
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
	import sitda_pkg::*;
#(
	parameter int MAX_DIGITS = 10
) (
	input logic                 clk,
	input logic                 arst_n,
	sitda_stream_if.sink        number,
	sitda_stream_if.source      chars
);

	localparam int BCD_W = MAX_DIGITS * DIGIT_W;
	localparam int DL_W  = $clog2(MAX_DIGITS + 1);

	// control state
	sitda_state_t           state_q, state_d;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;      // remaining shift steps minus one
	logic [DL_W-1:0]        dig_left_q;     // digits still to emit
	logic                   sign_pend_q;    // minus sign not yet sent

	// datapath
	logic [VALUE_W-1:0]     mag_q;          // magnitude, shifted out msb first
	logic [BCD_W-1:0]       bcd_q;          // packed bcd digits, top digit leads
	logic                   ovf_q;          // value has more digits than the buffer
	logic                   neg_q;

	logic [BCD_W-1:0]       bcd_adj;
	logic [DIGIT_W-1:0]     top_digit;
	logic [VALUE_W-1:0]     mag_in;
	logic                   in_acc;
	logic                   out_acc;
	logic                   skip_zero;

	assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
	assign in_acc    = number.valid & number.ready;
	assign out_acc   = chars.valid & chars.ready;

	// two's complement magnitude, exact for the most negative value
	assign mag_in = number.data.value[VALUE_W-1] ?
		(~number.data.value + VALUE_W'(1)) : number.data.value;

	// add-3 correction on every digit before the shift (independent per digit)
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_FIVE) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// leading zero may be dropped unless digits were lost off the top
	// or it is the only digit left
	assign skip_zero = !ovf_q && (top_digit == '0) && (dig_left_q > DL_W'(1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d               = state_q;
		number.ready          = 1'b0;
		chars.valid           = 1'b0;
		chars.data.char_code  = CHAR_ZERO + CHAR_W'(top_digit);
		chars.data.last_char  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				number.ready = 1'b1;
				if (number.valid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (bit_cnt_q == '0) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!skip_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				chars.valid = 1'b1;
				if (sign_pend_q) begin
					chars.data.char_code = CHAR_MINUS;
				end else begin
					chars.data.last_char = (dig_left_q == DL_W'(1));
					if (chars.ready && dig_left_q == DL_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q   <= '0;
			dig_left_q  <= '0;
			sign_pend_q <= 1'b0;
		end else begin
			if (in_acc) begin
				bit_cnt_q   <= BIT_CNT_W'(VALUE_W - 1);
				dig_left_q  <= DL_W'(MAX_DIGITS);
				sign_pend_q <= number.data.value[VALUE_W-1];
			end else if (state_q == ST_CONV) begin
				bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
			end else if (state_q == ST_SCAN && skip_zero) begin
				dig_left_q <= dig_left_q - DL_W'(1);
			end else if (out_acc) begin
				if (sign_pend_q) begin
					sign_pend_q <= 1'b0;
				end else begin
					dig_left_q <= dig_left_q - DL_W'(1);
				end
			end
		end
	end

	// bit-serial double dabble, then digit shifts for skip and emit
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= mag_in;
			bcd_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= number.data.value[VALUE_W-1];
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
			ovf_q <= ovf_q | bcd_adj[BCD_W-1];
		end else if ((state_q == ST_SCAN && skip_zero) || (out_acc && !sign_pend_q)) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	// emitted digits are always decimal
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !sign_pend_q) |-> (top_digit <= 4'd9))
		else $error("non-decimal digit offered");

	// a digit count of zero never reaches the output
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (dig_left_q != '0))
		else $error("emit with no digits left");

	// the last character returns the core to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && chars.data.last_char) |=> (state_q == ST_IDLE))
		else $error("core busy after last character");

	// the minus sign only appears for negative values and is never last
	assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.data.char_code == CHAR_MINUS) |->
			(neg_q && !chars.data.last_char))
		else $error("misplaced minus sign");

endmodule

// File: tb/sv/sitda_text_checker.sv
// ----------------------------------------------------------------------------
// sitda_text_checker
// watches the number and character channels, predicts the decimal text of
// every accepted number and compares each accepted character against it
// ----------------------------------------------------------------------------
module sitda_text_checker
	import sitda_pkg::*;
#(
	parameter int MAX_DIGITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       num_valid,
	input  logic       num_ready,
	input  num_item_t  num_data,
	input  logic       chr_valid,
	input  logic       chr_ready,
	input  char_item_t chr_data,
	output int         mismatches,
	output int         pending,
	output int         chars_checked
);

	char_item_t expected_chars[$];

	initial begin
		mismatches    = 0;
		pending       = 0;
		chars_checked = 0;
	end

	// one line per mismatch
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// decimal text of one number, digits peeled off least significant first
	function automatic void predict_text(input logic [VALUE_W-1:0] bits);
		logic [VALUE_W-1:0] mag;
		logic [DIGIT_W-1:0] digs [MAX_DIGITS];
		logic               neg;
		int                 n;
		neg = bits[VALUE_W-1];
		mag = neg ? (~bits + 1'b1) : bits;
		n   = 0;
		do begin
			digs[n] = DIGIT_W'(mag % 10);
			n++;
			mag = mag / 10;
		end while (mag != 0 && n < MAX_DIGITS);
		if (neg)
			expected_chars.push_back('{char_code: CHAR_MINUS, last_char: 1'b0});
		for (int k = n - 1; k >= 0; k--)
			expected_chars.push_back('{char_code: CHAR_ZERO + CHAR_W'(digs[k]),
				last_char: (k == 0)});
	endfunction

	always @(posedge clk) begin
		char_item_t want;
		if (arst_n) begin
			if (num_valid && num_ready)
				predict_text(num_data.value);
			if (chr_valid && chr_ready) begin
				chars_checked++;
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("char 0x%02h with nothing expected",
						chr_data.char_code));
				end else begin
					want = expected_chars.pop_front();
					if (chr_data.char_code !== want.char_code)
						report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
							chr_data.char_code, want.char_code));
					if (chr_data.last_char !== want.last_char)
						report_mismatch($sformatf("last_char %b, expected %b on 0x%02h",
							chr_data.last_char, want.last_char, want.char_code));
				end
			end
			pending = expected_chars.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives signed numbers into the decimal text core with random gaps and
// back-pressure; the checker beside it predicts and compares the characters
// ----------------------------------------------------------------------------
module tb_top
	import sitda_pkg::*;
();

	localparam int DIGITS      = 10;
	localparam int RAND_ITEMS  = 360;
	localparam int PHASE_LEN   = 40;
	localparam int TAIL_CYCLES = 120;

	logic clk;
	logic arst_n;
	// when set, neither side idles: back-to-back numbers, ready held high
	logic no_gaps;

	int mismatches;
	int pending;
	int chars_checked;
	int numbers_sent;
	int negatives_sent;
	int zeros_sent;
	int ready_hold;

	sitda_stream_if #(.T(num_item_t))  num_if ();
	sitda_stream_if #(.T(char_item_t)) chr_if ();

	signed_int_to_decimal_ascii_core #(
		.MAX_DIGITS(DIGITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.number(num_if),
		.chars (chr_if)
	);

	sitda_text_checker #(
		.MAX_DIGITS(DIGITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.num_valid    (num_if.valid),
		.num_ready    (num_if.ready),
		.num_data     (num_if.data),
		.chr_valid    (chr_if.valid),
		.chr_ready    (chr_if.ready),
		.chr_data     (chr_if.data),
		.mismatches   (mismatches),
		.pending      (pending),
		.chars_checked(chars_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling: every number at full length with the longest stalls
	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// idle lengths: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	function automatic int pow10(input int k);
		int p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	// random number drawn from a few classes so every digit count and
	// both signs show up often, not only ten-digit magnitudes
	function automatic logic [VALUE_W-1:0] rand_number();
		int          d;
		int unsigned lo;
		int unsigned hi;
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom();
			1: v = $urandom_range(0, 999);
			2: v = pow10($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
			3: begin
				d  = $urandom_range(1, 10);
				lo = (d == 1) ? 0 : pow10(d - 1);
				hi = (d == 10) ? 32'h7fff_ffff : pow10(d) - 1;
				v  = $urandom_range(hi, lo);
			end
			default: v = 32'h7fff_ffff - $urandom_range(0, 3);
		endcase
		// flip to the negative side half the time; the largest magnitude
		// plus one on the negative side is the most negative value
		if ($urandom_range(0, 1))
			v = ~v + ($urandom_range(0, 3) == 0 ? 1'b0 : 1'b1);
		return v;
	endfunction

	// offer one number and hold it until the core takes it
	task automatic send_number(input logic [VALUE_W-1:0] v);
		num_if.valid      <= 1'b1;
		num_if.data.value <= v;
		do @(posedge clk); while (!num_if.ready);
		numbers_sent++;
		if (v[VALUE_W-1])
			negatives_sent++;
		if (v == '0)
			zeros_sent++;
	endtask

	// idle the number side after an accepted item; valid stays high when no
	// gap follows so the next item goes out back to back
	task automatic idle_after_item();
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap != 0) begin
			num_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// character side back-pressure: stall runs and ready runs of random length
	always @(posedge clk) begin
		if (!arst_n) begin
			chr_if.ready <= 1'b0;
			ready_hold   = 0;
		end else if (no_gaps) begin
			chr_if.ready <= 1'b1;
			ready_hold   = 0;
		end else if (ready_hold != 0) begin
			ready_hold--;
		end else if (chr_if.ready) begin
			ready_hold = pick_gap();
			if (ready_hold != 0) begin
				chr_if.ready <= 1'b0;
				ready_hold--;
			end
		end else begin
			chr_if.ready <= 1'b1;
			ready_hold   = $urandom_range(0, 6);
		end
	end

	initial begin
		logic [VALUE_W-1:0] directed [$];
		// extremes of the range, zero, digit-count boundaries on both sides
		directed = '{
			32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'sd10,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h7fff_fffe,
			32'd99, 32'd100, -32'sd100, 32'd999_999_999, 32'd1_000_000_000,
			-32'sd999_999_999, -32'sd1_000_000_000, 32'd12_345, -32'sd5,
			32'haaaa_aaaa, 32'h5555_5555
		};

		arst_n            = 1'b0;
		no_gaps           = 1'b0;
		num_if.valid      = 1'b0;
		num_if.data       = '0;
		numbers_sent      = 0;
		negatives_sent    = 0;
		zeros_sent        = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with idling on both sides
		foreach (directed[i]) begin
			send_number(directed[i]);
			idle_after_item();
		end

		// random part in phases, some of them with no idling at all
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % PHASE_LEN == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			send_number(rand_number());
			idle_after_item();
		end
		num_if.valid <= 1'b0;
		no_gaps      = 1'b0;

		// let the checker pick up the last item, then drain the text
		@(posedge clk);
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d numbers (%0d negative, %0d zero, both 32-bit extremes)",
			numbers_sent, negatives_sent, zeros_sent);
		$display("%0d characters checked, %0d mismatches", chars_checked, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
